// ----- hdl/generational_slot_allocator_macros.svh -----
// Assertion macros used by the checker file of the slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define GSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define GSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/gsa_pkg.sv -----
// Shared constants, types and helper functions of the generational slot allocator.
package gsa_pkg;
    localparam int MAX_SLOTS   = 1024;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int GEN_W       = 16;
    localparam int WORD_BITS   = 32;
    localparam int WORD_W      = $clog2(WORD_BITS);
    localparam int MAP_WORDS   = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAP_W       = $clog2(MAP_WORDS);
    localparam int DEFER_DEPTH = 64;
    localparam int DEFER_W     = $clog2(DEFER_DEPTH);
    localparam int EXT_W       = SLOT_W + 1;
    localparam int CNT_W       = DEFER_W + 1;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_CHECK   = 3'd2,
        OP_DEFER   = 3'd3,
        OP_FLUSH   = 3'd4,
        OP_CLEAR   = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_QFULL  = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_FIND, S_GENW, S_SET, S_CHK, S_QRD, S_QMAP, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_alloc;
        logic rd_id;
        logic rd_gen;
        logic res_full;
        logic res_range;
        logic alloc;
        logic gen_wr;
        logic set_free;
        logic chk;
        logic defer;
        logic clear;
        logic q_rd;
        logic q_map;
        logic flush_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic avail_any;
        logic id_range;
        logic flush_done;
        logic out_free;
    } t_sts;

    // Lowest set bit of a map word; zero when the word is empty.
    function automatic logic [WORD_W-1:0] first_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_W-1:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (w[k]) idx = WORD_W'(k);
        end
        return idx;
    endfunction

    // Lowest word that still holds a free slot.
    function automatic logic [MAP_W-1:0] first_word(input logic [MAP_WORDS-1:0] w);
        logic [MAP_W-1:0] idx;
        idx = '0;
        for (int k = MAP_WORDS - 1; k >= 0; k--) begin
            if (w[k]) idx = MAP_W'(k);
        end
        return idx;
    endfunction
endpackage

// ----- hdl/gsa_ctrl.sv -----
// Sequencing state machine of the slot allocator.
module gsa_ctrl import gsa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                case (i_sts.op)
                    OP_CREATE: begin
                        if (i_sts.avail_any) begin
                            o_cmd.rd_alloc = 1'b1;
                            n_state = S_FIND;
                        end else begin
                            o_cmd.res_full = 1'b1;
                        end
                    end
                    OP_DESTROY: begin
                        if (i_sts.id_range) begin
                            o_cmd.res_range = 1'b1;
                        end else begin
                            o_cmd.rd_id = 1'b1;
                            n_state = S_SET;
                        end
                    end
                    OP_CHECK: begin
                        if (i_sts.id_range) begin
                            o_cmd.res_range = 1'b1;
                        end else begin
                            o_cmd.rd_gen = 1'b1;
                            n_state = S_CHK;
                        end
                    end
                    OP_DEFER: o_cmd.defer = 1'b1;
                    OP_FLUSH: n_state = S_QRD;
                    OP_CLEAR: o_cmd.clear = 1'b1;
                    default: n_state = S_OUT;
                endcase
            end
            S_FIND: begin
                o_cmd.alloc = 1'b1;
                n_state = S_GENW;
            end
            S_GENW: begin
                o_cmd.gen_wr = 1'b1;
                n_state = S_OUT;
            end
            S_SET: begin
                o_cmd.set_free = 1'b1;
                n_state = (i_sts.op == OP_FLUSH) ? S_QRD : S_OUT;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = S_OUT;
            end
            S_QRD: begin
                if (i_sts.flush_done) begin
                    o_cmd.flush_end = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state = S_QMAP;
                end
            end
            S_QMAP: begin
                o_cmd.q_map = 1'b1;
                n_state = S_SET;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- hdl/gsa_datapath.sv -----
// Free map, generation store, defer queue and output register of the slot allocator.
module gsa_datapath import gsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [2:0]        i_opcode,
    input  logic [SLOT_W-1:0] i_entity_id,
    input  logic [GEN_W-1:0]  i_entity_gen,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_new_id,
    output logic [GEN_W-1:0]  o_new_gen,
    output logic              o_is_valid
);
    logic [WORD_BITS-1:0] r_map_mem [MAP_WORDS];
    logic [GEN_W-1:0]     r_gen_mem [MAX_SLOTS];
    logic [SLOT_W-1:0]    r_q_mem   [DEFER_DEPTH];

    logic [MAP_WORDS-1:0] r_mvld, r_avail;
    logic [WORD_BITS-1:0] r_map_q;
    logic                 r_map_rv;
    logic [GEN_W-1:0]     r_gen_q;
    logic [SLOT_W-1:0]    r_q_q;
    logic [EXT_W-1:0]     r_extent;
    logic [CNT_W-1:0]     r_count, r_fidx;
    logic [2:0]           r_op;
    logic [SLOT_W-1:0]    r_id, r_tgt, r_slot;
    logic [GEN_W-1:0]     r_gen_in;
    logic [MAP_W-1:0]     r_widx;
    logic [1:0]           r_res_status;
    logic [SLOT_W-1:0]    r_res_id;
    logic [GEN_W-1:0]     r_res_gen;
    logic                 r_res_valid;
    logic                 r_out_valid;
    logic [1:0]           r_o_status;
    logic [SLOT_W-1:0]    r_o_id;
    logic [GEN_W-1:0]     r_o_gen;
    logic                 r_o_isv;

    logic [WORD_BITS-1:0] map_word, alloc_word, free_word;
    logic [WORD_W-1:0]    alloc_bit;
    logic [SLOT_W-1:0]    alloc_slot;
    logic [MAP_W-1:0]     map_raddr;
    logic [SLOT_W-1:0]    gen_raddr;
    logic [GEN_W-1:0]     issued_gen;

    // A word never written since clear reads as all free.
    assign map_word   = r_map_rv ? r_map_q : '1;
    assign alloc_bit  = first_set(map_word);
    assign alloc_word = map_word & ~(WORD_BITS'(1) << alloc_bit);
    assign free_word  = map_word | (WORD_BITS'(1) << r_tgt[WORD_W-1:0]);
    assign alloc_slot = SLOT_W'({r_widx, alloc_bit});
    // Slots at or above the extent were not handed out since reset or clear, so their counter reads as zero.
    assign issued_gen = ({1'b0, r_slot} < r_extent) ? r_gen_q : '0;

    always_comb begin
        map_raddr = r_tgt[SLOT_W-1:WORD_W];
        if (i_cmd.rd_alloc) map_raddr = first_word(r_avail);
        else if (i_cmd.rd_id) map_raddr = r_id[SLOT_W-1:WORD_W];
        else if (i_cmd.q_map) map_raddr = r_q_q[SLOT_W-1:WORD_W];
        gen_raddr = i_cmd.alloc ? alloc_slot : r_id;
    end

    always_ff @(posedge i_clk) begin
        r_map_q  <= r_map_mem[map_raddr];
        r_map_rv <= r_mvld[map_raddr];
        r_gen_q  <= r_gen_mem[gen_raddr];
        r_q_q    <= r_q_mem[r_fidx[DEFER_W-1:0]];
        if (i_cmd.alloc) r_map_mem[r_widx] <= alloc_word;
        else if (i_cmd.set_free) r_map_mem[r_tgt[SLOT_W-1:WORD_W]] <= free_word;
        if (i_cmd.gen_wr) r_gen_mem[r_slot] <= issued_gen + GEN_W'(1);
        if (i_cmd.defer && r_count < CNT_W'(DEFER_DEPTH)) begin
            r_q_mem[r_count[DEFER_W-1:0]] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld      <= '0;
            r_avail     <= '1;
            r_extent    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_mvld   <= '0;
                r_avail  <= '1;
                r_extent <= '0;
            end
            if (i_cmd.alloc) begin
                r_mvld[r_widx]  <= 1'b1;
                r_avail[r_widx] <= |alloc_word;
            end
            if (i_cmd.set_free) begin
                r_mvld[r_tgt[SLOT_W-1:WORD_W]]  <= 1'b1;
                r_avail[r_tgt[SLOT_W-1:WORD_W]] <= 1'b1;
            end
            if (i_cmd.gen_wr && {1'b0, r_slot} >= r_extent) begin
                r_extent <= EXT_W'(r_slot) + EXT_W'(1);
            end
            if (i_cmd.defer && r_count < CNT_W'(DEFER_DEPTH)) r_count <= r_count + CNT_W'(1);
            if (i_cmd.flush_end) r_count <= '0;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_opcode;
            r_id         <= i_entity_id;
            r_gen_in     <= i_entity_gen;
            r_fidx       <= '0;
            r_res_status <= ST_OK;
            r_res_id     <= '0;
            r_res_gen    <= '0;
            r_res_valid  <= 1'b0;
        end
        if (i_cmd.rd_alloc) r_widx <= first_word(r_avail);
        if (i_cmd.rd_id) r_tgt <= r_id;
        if (i_cmd.res_full) r_res_status <= ST_FULL;
        if (i_cmd.res_range) r_res_status <= ST_RANGE;
        if (i_cmd.alloc) r_slot <= alloc_slot;
        if (i_cmd.gen_wr) begin
            r_res_id  <= r_slot;
            r_res_gen <= issued_gen;
        end
        if (i_cmd.chk) begin
            r_res_valid <= ({1'b0, r_id} < r_extent) && (r_gen_in == r_gen_q - GEN_W'(1));
        end
        if (i_cmd.defer) begin
            if ({1'b0, r_id} >= EXT_W'(MAX_SLOTS)) r_res_status <= ST_RANGE;
            else if (r_count >= CNT_W'(DEFER_DEPTH)) r_res_status <= ST_QFULL;
        end
        if (i_cmd.q_rd) r_fidx <= r_fidx + CNT_W'(1);
        if (i_cmd.q_map) r_tgt <= r_q_q;
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_id     <= r_res_id;
            r_o_gen    <= r_res_gen;
            r_o_isv    <= r_res_valid;
        end
    end

    assign o_sts.op         = t_op'(r_op);
    assign o_sts.avail_any  = |r_avail;
    assign o_sts.id_range   = ({1'b0, r_id} >= EXT_W'(MAX_SLOTS));
    assign o_sts.flush_done = (r_fidx >= r_count);
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid    = r_out_valid;
    assign o_status   = r_o_status;
    assign o_new_id   = r_o_id;
    assign o_new_gen  = r_o_gen;
    assign o_is_valid = r_o_isv;
endmodule

// ----- hdl/generational_slot_allocator.sv -----
// Top level of the generational slot allocator.
// The block takes one command word on the input channel (i_valid, o_stall) and
// returns exactly one result word on the output channel (o_valid, i_stall).
// Create hands out the lowest free slot with its current generation, destroy
// frees a slot, check compares a generation with the one last issued, defer
// queues an id, flush frees every queued id and clear-all empties the allocator.
// A command is taken only while the sequencer is idle, one word at a time.
// Create reads the free map, takes the lowest free bit and writes back the
// generation store; destroy reads the map word and then frees the slot; check
// reads the generation store; flush reads each queued id and frees it in turn.
// The next command can be taken the cycle after the result is registered, so a
// new word is never taken before the last one is through.
// Reset marks every slot free, sets all generations to zero and empties the
// queue without any clearing pass: generations above the allocated extent
// read as zero, and map words not yet written read as all free.
// When the receiver stalls, the result stays in the output register and the
// sequencer waits before taking the next word.
module generational_slot_allocator import gsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_opcode,
    input  logic [SLOT_W-1:0] i_entity_id,
    input  logic [GEN_W-1:0]  i_entity_gen,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_new_id,
    output logic [GEN_W-1:0]  o_new_gen,
    output logic              o_is_valid
);
    t_cmd cmd;
    t_sts sts;

    // The controller steps through each command; the datapath owns all storage.
    gsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gsa_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_opcode),
        .i_entity_id  (i_entity_id),
        .i_entity_gen (i_entity_gen),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_new_id     (o_new_id),
        .o_new_gen    (o_new_gen),
        .o_is_valid   (o_is_valid)
    );
endmodule

// ----- hdl/gsa_checker.sv -----
// Port-level checker of the slot allocator and its bind statement.
`include "generational_slot_allocator_macros.svh"
module gsa_checker import gsa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_status,
    input logic [SLOT_W-1:0] o_new_id,
    input logic [GEN_W-1:0]  o_new_gen,
    input logic              o_is_valid
);
    `GSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_new_gen), "stalled result word changed")
    `GSA_ASSERT_NOW(a_full_zero, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_new_id == '0 && o_new_gen == '0 && !o_is_valid, "failed create carries data")
    `GSA_ASSERT_NOW(a_valid_ok, i_clk, i_rst_n, o_valid && o_is_valid, o_status == ST_OK && o_new_gen == '0, "valid check with bad status")
    `GSA_ASSERT_NEXT(a_one_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "second word taken while busy")
endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);
